// ----- rtl/cfd_pkg.sv -----
// ----------------------------------------------------------------------------
// cfd_pkg
// shared types, codes and the crc step for the framed packet deframer
// ----------------------------------------------------------------------------
package cfd_pkg;

  localparam int BYTE_W     = 8;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 4;
  localparam int QCNT_OUT_W = 3;
  localparam int LEN_W      = 16;
  localparam int CRC_W      = 16;
  localparam int CFG_IDX_W  = 3;

  localparam int PAYLOAD_MAX_DEF = 255;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  // operations
  localparam logic [OP_W-1:0] OP_BYTE = 2'd0;
  localparam logic [OP_W-1:0] OP_TAKE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEND = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  // result status
  localparam logic [STATUS_W-1:0] ST_NONE        = 4'd0;
  localparam logic [STATUS_W-1:0] ST_VERSION     = 4'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FIELD   = 4'd2;
  localparam logic [STATUS_W-1:0] ST_LENGTH      = 4'd3;
  localparam logic [STATUS_W-1:0] ST_CRC         = 4'd4;
  localparam logic [STATUS_W-1:0] ST_ACK_FORMAT  = 4'd5;
  localparam logic [STATUS_W-1:0] ST_UNEXP_ACK   = 4'd6;
  localparam logic [STATUS_W-1:0] ST_QUEUE_FULL  = 4'd7;
  localparam logic [STATUS_W-1:0] ST_DELIVERED   = 4'd8;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE   = 4'd9;
  localparam logic [STATUS_W-1:0] ST_ACK_MATCHED = 4'd10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TYPE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_MASK     = 3'd4;

  localparam logic [BYTE_W-1:0] START_FIRST_RST  = 8'hAA;
  localparam logic [BYTE_W-1:0] START_SECOND_RST = 8'h55;
  localparam logic [BYTE_W-1:0] VERSION_RST      = 8'h01;
  localparam logic [BYTE_W-1:0] ACK_TYPE_RST     = 8'h01;
  localparam logic [BYTE_W-1:0] ACK_MASK_RST     = 8'h01;

  typedef struct packed {
    logic [BYTE_W-1:0] start_first;
    logic [BYTE_W-1:0] start_second;
    logic [BYTE_W-1:0] version;
    logic [BYTE_W-1:0] ack_type;
    logic [BYTE_W-1:0] ack_mask;
  } cfg_t;

  // classified word handed from the parser to the frame handler
  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [BYTE_W-1:0]   tx_seq;
    logic [STATUS_W-1:0] status;
    logic                pay_valid;
    logic [BYTE_W-1:0]   pay_byte;
    logic [BYTE_W-1:0]   ftype;
    logic [BYTE_W-1:0]   fflags;
    logic [BYTE_W-1:0]   fseq;
    logic [BYTE_W-1:0]   flen;
    logic                frame_good;
    logic                is_ack;
    logic                ack_bad;
    logic                want_ack;
    logic [CRC_W-1:0]    crc;
  } tok_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic                  payload_valid;
    logic [BYTE_W-1:0]     payload_byte;
    logic [BYTE_W-1:0]     frame_type;
    logic [BYTE_W-1:0]     frame_flags;
    logic [BYTE_W-1:0]     frame_seq;
    logic [BYTE_W-1:0]     frame_len;
    logic                  send_ack;
    logic [QCNT_OUT_W-1:0] queued_frames;
    logic                  ack_pending;
  } res_t;

  function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < BYTE_W; i++) begin
      c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/cfd_if.sv -----
// ----------------------------------------------------------------------------
// cfd_if
// handshake channels of the deframer: input words, results, register writes
// ----------------------------------------------------------------------------
interface cfd_in_if;
  logic                            valid;
  logic                            ready;
  logic [cfd_pkg::OP_W-1:0]        op;
  logic [cfd_pkg::BYTE_W-1:0]      data;
  logic [cfd_pkg::BYTE_W-1:0]      sent_seq;

  modport source (output valid, op, data, sent_seq, input ready);
  modport sink   (input valid, op, data, sent_seq, output ready);
endinterface

interface cfd_out_if;
  logic                            valid;
  logic                            ready;
  logic [cfd_pkg::STATUS_W-1:0]    status;
  logic                            payload_valid;
  logic [cfd_pkg::BYTE_W-1:0]      payload_byte;
  logic [cfd_pkg::BYTE_W-1:0]      frame_type;
  logic [cfd_pkg::BYTE_W-1:0]      frame_flags;
  logic [cfd_pkg::BYTE_W-1:0]      frame_seq;
  logic [cfd_pkg::BYTE_W-1:0]      frame_len;
  logic                            send_ack;
  logic [cfd_pkg::QCNT_OUT_W-1:0]  queued_frames;
  logic                            ack_pending;

  modport source (output valid, status, payload_valid, payload_byte, frame_type,
                  frame_flags, frame_seq, frame_len, send_ack, queued_frames,
                  ack_pending, input ready);
  modport sink   (input valid, status, payload_valid, payload_byte, frame_type,
                  frame_flags, frame_seq, frame_len, send_ack, queued_frames,
                  ack_pending, output ready);
endinterface

interface cfd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cfd_pkg::CFG_IDX_W-1:0]   reg_index;
  logic [cfd_pkg::BYTE_W-1:0]      wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ----- rtl/cfd_front.sv -----
// ----------------------------------------------------------------------------
// cfd_front
// frame parser: start hunt, header checks, payload forwarding, crc check
// ----------------------------------------------------------------------------
module cfd_front #(
  parameter int PAYLOAD_MAX = cfd_pkg::PAYLOAD_MAX_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cfd_pkg::cfg_t cfg,
  cfd_in_if.sink        in_ch,
  output logic          tok_valid,
  input  logic          tok_ready,
  output cfd_pkg::tok_t tok
);
  import cfd_pkg::*;

  localparam int POS_W = $clog2(PAYLOAD_MAX + 1);

  localparam logic [2:0] PH_HUNT0   = 3'd0;
  localparam logic [2:0] PH_HUNT1   = 3'd1;
  localparam logic [2:0] PH_HEADER  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CRC0    = 3'd4;
  localparam logic [2:0] PH_CRC1    = 3'd5;

  logic [2:0]        phase_r, phase_nxt;
  logic [2:0]        hdr_pos_r, hdr_pos_nxt;
  logic [POS_W-1:0]  pay_pos_r, pay_pos_nxt;
  logic [LEN_W-1:0]  exp_len_r, exp_len_nxt;
  logic [CRC_W-1:0]  crc_r, crc_nxt;
  logic [BYTE_W-1:0] crc_lo_r, crc_lo_nxt;
  logic [BYTE_W-1:0] type_r, type_nxt;
  logic [BYTE_W-1:0] flags_r, flags_nxt;
  logic [BYTE_W-1:0] seq_r, seq_nxt;

  logic [BYTE_W-1:0] b;
  logic [CRC_W-1:0]  crc_upd;
  logic [POS_W-1:0]  pos_inc;
  logic [LEN_W-1:0]  full_len;
  logic [2:0]        restart_phase;
  logic              restart;
  logic              take_byte;

  assign b             = in_ch.data;
  assign crc_upd       = crc_step(crc_r, b);
  assign pos_inc       = pay_pos_r + 1'b1;
  assign full_len      = {b, exp_len_r[BYTE_W-1:0]};
  assign restart_phase = (b == cfg.start_first) ? PH_HUNT1 : PH_HUNT0;

  assign in_ch.ready = tok_ready;
  assign tok_valid   = in_ch.valid;
  assign take_byte   = in_ch.valid && tok_ready && (in_ch.op == OP_BYTE);

  always_comb begin
    phase_nxt   = phase_r;
    hdr_pos_nxt = hdr_pos_r;
    pay_pos_nxt = pay_pos_r;
    exp_len_nxt = exp_len_r;
    crc_nxt     = crc_r;
    crc_lo_nxt  = crc_lo_r;
    type_nxt    = type_r;
    flags_nxt   = flags_r;
    seq_nxt     = seq_r;
    restart     = 1'b0;

    tok            = '0;
    tok.op         = in_ch.op;
    tok.tx_seq     = in_ch.sent_seq;
    tok.status     = ST_NONE;
    tok.is_ack     = (type_r == cfg.ack_type);
    tok.ack_bad    = (flags_r != '0) || (exp_len_r != '0);
    tok.want_ack   = ((flags_r & cfg.ack_mask) != '0);
    tok.crc        = crc_r;

    unique case (phase_r)
      PH_HUNT0: begin
        if (b == cfg.start_first) phase_nxt = PH_HUNT1;
      end
      PH_HUNT1: begin
        if (b == cfg.start_second) begin
          phase_nxt   = PH_HEADER;
          hdr_pos_nxt = '0;
          crc_nxt     = CRC_INIT;
        end else if (b != cfg.start_first) begin
          phase_nxt = PH_HUNT0;
        end
      end
      PH_HEADER: begin
        crc_nxt     = crc_upd;
        hdr_pos_nxt = hdr_pos_r + 1'b1;
        unique case (hdr_pos_r)
          3'd0: begin
            if (b != cfg.version) begin
              tok.status = ST_VERSION;
              restart    = 1'b1;
            end
          end
          3'd1: begin
            if (b == '0) begin
              tok.status = ST_BAD_FIELD;
              restart    = 1'b1;
            end else begin
              type_nxt = b;
            end
          end
          3'd2: begin
            if ((b & ~cfg.ack_mask) != '0) begin
              tok.status = ST_BAD_FIELD;
              restart    = 1'b1;
            end else begin
              flags_nxt = b;
            end
          end
          3'd3: seq_nxt = b;
          3'd4: exp_len_nxt = LEN_W'(b);
          default: begin
            exp_len_nxt = full_len;
            if (full_len > LEN_W'(PAYLOAD_MAX)) begin
              tok.status = ST_LENGTH;
              restart    = 1'b1;
            end else begin
              pay_pos_nxt = '0;
              phase_nxt   = (full_len == '0) ? PH_CRC0 : PH_PAYLOAD;
            end
          end
        endcase
      end
      PH_PAYLOAD: begin
        tok.pay_valid = 1'b1;
        tok.pay_byte  = b;
        pay_pos_nxt   = pos_inc;
        crc_nxt       = crc_upd;
        if (LEN_W'(pos_inc) >= exp_len_r) phase_nxt = PH_CRC0;
      end
      PH_CRC0: begin
        crc_lo_nxt = b;
        phase_nxt  = PH_CRC1;
      end
      PH_CRC1: begin
        tok.ftype  = type_r;
        tok.fflags = flags_r;
        tok.fseq   = seq_r;
        tok.flen   = exp_len_r[BYTE_W-1:0];
        if ({b, crc_lo_r} != crc_r) begin
          tok.status = ST_CRC;
          restart    = 1'b1;
        end else begin
          tok.frame_good = 1'b1;
          phase_nxt      = PH_HUNT0;
          hdr_pos_nxt    = '0;
          pay_pos_nxt    = '0;
          crc_nxt        = CRC_INIT;
        end
      end
      default: restart = 1'b1;
    endcase

    if (restart) begin
      phase_nxt   = restart_phase;
      hdr_pos_nxt = '0;
      pay_pos_nxt = '0;
      crc_nxt     = CRC_INIT;
    end

    if (in_ch.op != OP_BYTE) begin
      tok.status    = ST_NONE;
      tok.pay_valid = 1'b0;
      tok.pay_byte  = '0;
      tok.ftype     = '0;
      tok.fflags    = '0;
      tok.fseq      = '0;
      tok.flen      = '0;
      tok.frame_good = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT0;
      hdr_pos_r <= '0;
      pay_pos_r <= '0;
      crc_r     <= CRC_INIT;
    end else if (take_byte) begin
      phase_r   <= phase_nxt;
      hdr_pos_r <= hdr_pos_nxt;
      pay_pos_r <= pay_pos_nxt;
      crc_r     <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_byte) begin
      exp_len_r <= exp_len_nxt;
      crc_lo_r  <= crc_lo_nxt;
      type_r    <= type_nxt;
      flags_r   <= flags_nxt;
      seq_r     <= seq_nxt;
    end
  end

endmodule

// ----- rtl/cfd_fifo.sv -----
// ----------------------------------------------------------------------------
// cfd_fifo
// short word queue between the parser and the frame handler
// ----------------------------------------------------------------------------
module cfd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  cfd_pkg::tok_t in_tok,
  output logic          out_valid,
  input  logic          out_ready,
  output cfd_pkg::tok_t out_tok
);
  import cfd_pkg::*;

  tok_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r;
  logic                  push;
  logic                  pop;

  assign in_ready  = (cnt_r != FIFO_CNT_W'(FIFO_DEPTH));
  assign out_valid = (cnt_r != '0);
  assign out_tok   = mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= in_tok;
  end

endmodule

// ----- rtl/cfd_back.sv -----
// ----------------------------------------------------------------------------
// cfd_back
// frame handler: ack matching, duplicate filter, frame count, result register
// ----------------------------------------------------------------------------
module cfd_back #(
  parameter int QUEUE_DEPTH = cfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          tok_valid,
  output logic          tok_ready,
  input  cfd_pkg::tok_t tok,
  cfd_out_if.source     out_ch
);
  import cfd_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              awaiting_r, awaiting_nxt;
  logic [BYTE_W-1:0] pending_r, pending_nxt;
  logic              have_sig_r, have_sig_nxt;
  logic [BYTE_W-1:0] last_seq_r, last_seq_nxt;
  logic [CRC_W-1:0]  last_crc_r, last_crc_nxt;
  logic              out_valid_r;
  res_t              res_r, res_nxt;
  logic [CNT_W+2:0]  cnt_ext;
  logic              pop;

  assign tok_ready = !out_valid_r || out_ch.ready;
  assign pop       = tok_valid && tok_ready;
  assign cnt_ext   = (CNT_W+3)'(cnt_nxt);

  always_comb begin
    cnt_nxt      = cnt_r;
    awaiting_nxt = awaiting_r;
    pending_nxt  = pending_r;
    have_sig_nxt = have_sig_r;
    last_seq_nxt = last_seq_r;
    last_crc_nxt = last_crc_r;

    res_nxt               = '0;
    res_nxt.status        = tok.status;
    res_nxt.payload_valid = tok.pay_valid;
    res_nxt.payload_byte  = tok.pay_byte;
    res_nxt.frame_type    = tok.ftype;
    res_nxt.frame_flags   = tok.fflags;
    res_nxt.frame_seq     = tok.fseq;
    res_nxt.frame_len     = tok.flen;

    unique case (tok.op)
      OP_TAKE: begin
        if (cnt_r != '0) cnt_nxt = cnt_r - 1'b1;
      end
      OP_SEND: begin
        awaiting_nxt = 1'b1;
        pending_nxt  = tok.tx_seq;
      end
      OP_BYTE: begin
        if (tok.frame_good) begin
          if (tok.is_ack) begin
            if (tok.ack_bad) begin
              res_nxt.status = ST_ACK_FORMAT;
            end else if (awaiting_r && (pending_r == tok.fseq)) begin
              awaiting_nxt   = 1'b0;
              res_nxt.status = ST_ACK_MATCHED;
            end else begin
              res_nxt.status = ST_UNEXP_ACK;
            end
          end else if (have_sig_r && (last_seq_r == tok.fseq) &&
                       (last_crc_r == tok.crc)) begin
            res_nxt.status   = ST_DUPLICATE;
            res_nxt.send_ack = tok.want_ack;
          end else if (cnt_r >= CNT_W'(QUEUE_DEPTH)) begin
            res_nxt.status = ST_QUEUE_FULL;
          end else begin
            cnt_nxt          = cnt_r + 1'b1;
            have_sig_nxt     = 1'b1;
            last_seq_nxt     = tok.fseq;
            last_crc_nxt     = tok.crc;
            res_nxt.status   = ST_DELIVERED;
            res_nxt.send_ack = tok.want_ack;
          end
        end
      end
      default: ;
    endcase

    res_nxt.queued_frames = cnt_ext[QCNT_OUT_W-1:0];
    res_nxt.ack_pending   = awaiting_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      awaiting_r  <= 1'b0;
      pending_r   <= '0;
      have_sig_r  <= 1'b0;
      last_seq_r  <= '0;
      last_crc_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        cnt_r      <= cnt_nxt;
        awaiting_r <= awaiting_nxt;
        pending_r  <= pending_nxt;
        have_sig_r <= have_sig_nxt;
        last_seq_r <= last_seq_nxt;
        last_crc_r <= last_crc_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) res_r <= res_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = res_r.status;
  assign out_ch.payload_valid = res_r.payload_valid;
  assign out_ch.payload_byte  = res_r.payload_byte;
  assign out_ch.frame_type    = res_r.frame_type;
  assign out_ch.frame_flags   = res_r.frame_flags;
  assign out_ch.frame_seq     = res_r.frame_seq;
  assign out_ch.frame_len     = res_r.frame_len;
  assign out_ch.send_ack      = res_r.send_ack;
  assign out_ch.queued_frames = res_r.queued_frames;
  assign out_ch.ack_pending   = res_r.ack_pending;

endmodule

// ----- rtl/crc16_frame_deframer_with_ack.sv -----
// ----------------------------------------------------------------------------
// crc16_frame_deframer_with_ack
// framed packet deframer with crc-16 check, duplicate filter and ack tracking
// ----------------------------------------------------------------------------
// One word is taken per clock cycle, sustained while the queue has room, and
// each word gives exactly one result word. The parser classifies the word in
// the cycle it is taken and pushes it into a two-entry queue at the edge that
// accepts it; the frame handler pops it when its output register is empty or
// being read, and loads the result into that register. The byte-wide crc
// step in the parser is the longest path. Register writes are taken at any
// time and must only be made while no word is in flight.
module crc16_frame_deframer_with_ack #(
  parameter int PAYLOAD_MAX = cfd_pkg::PAYLOAD_MAX_DEF,
  parameter int QUEUE_DEPTH = cfd_pkg::QUEUE_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  cfd_in_if.sink     in_ch,
  cfd_out_if.source  out_ch,
  cfd_cfg_if.sink    cfg_ch
);
  import cfd_pkg::*;

  logic [BYTE_W-1:0] start_first_r;
  logic [BYTE_W-1:0] start_second_r;
  logic [BYTE_W-1:0] version_r;
  logic [BYTE_W-1:0] ack_type_r;
  logic [BYTE_W-1:0] ack_mask_r;
  cfg_t              cfg;

  logic front_valid, front_ready;
  tok_t front_tok;
  logic back_valid, back_ready;
  tok_t back_tok;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_first_r  <= START_FIRST_RST;
      start_second_r <= START_SECOND_RST;
      version_r      <= VERSION_RST;
      ack_type_r     <= ACK_TYPE_RST;
      ack_mask_r     <= ACK_MASK_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        CFG_START_FIRST:  start_first_r  <= cfg_ch.wdata;
        CFG_START_SECOND: start_second_r <= cfg_ch.wdata;
        CFG_VERSION:      version_r      <= cfg_ch.wdata;
        CFG_ACK_TYPE:     ack_type_r     <= cfg_ch.wdata;
        CFG_ACK_MASK:     ack_mask_r     <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  assign cfg.start_first  = start_first_r;
  assign cfg.start_second = start_second_r;
  assign cfg.version      = version_r;
  assign cfg.ack_type     = ack_type_r;
  assign cfg.ack_mask     = ack_mask_r;

  cfd_front #(
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .tok_valid (front_valid),
    .tok_ready (front_ready),
    .tok       (front_tok)
  );

  cfd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_tok    (front_tok),
    .out_valid (back_valid),
    .out_ready (back_ready),
    .out_tok   (back_tok)
  );

  cfd_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (back_valid),
    .tok_ready (back_ready),
    .tok       (back_tok),
    .out_ch    (out_ch)
  );

endmodule
